>>> design/qoi_pixel_encoder_core_defines.svh
// Assertion macros for the QOI pixel encoder core.
// Included by the top level; the macros expand to nothing in synthesis builds.
`ifndef QOI_PIXEL_ENCODER_CORE_DEFINES_SVH
`define QOI_PIXEL_ENCODER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, clocked on aclk and disabled during reset.
`define QPE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("qpe assertion failed");
// Next-cycle implication, clocked on aclk and disabled during reset.
`define QPE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("qpe assertion failed");
`else
`define QPE_ASSERT_IMP(label, ante, cons)
`define QPE_ASSERT_NXT(label, ante, cons)
`endif
`endif

>>> design/qpe_pkg.sv
// Shared types, constants and functions of the QOI pixel encoder core.
// Used by qpe_front, qpe_queue, qpe_back and the top level; no dependencies.
`default_nettype none

package qpe_pkg;

    localparam int QPE_MAX_BYTES   = 6;
    localparam int QPE_QUEUE_DEPTH = 4;

    localparam logic [5:0] QPE_RUN_LIMIT = 6'd62;

    localparam logic [7:0] QPE_TAG_INDEX = 8'h00;
    localparam logic [7:0] QPE_TAG_DIFF  = 8'h40;
    localparam logic [7:0] QPE_TAG_LUMA  = 8'h80;
    localparam logic [7:0] QPE_TAG_RUN   = 8'hc0;
    localparam logic [7:0] QPE_TAG_RGB   = 8'hfe;
    localparam logic [7:0] QPE_TAG_RGBA  = 8'hff;

    // Pixel word: red in bits 7:0, green 15:8, blue 23:16, alpha 31:24.
    localparam logic [31:0] QPE_PIX_RESET = 32'hff00_0000;

    // All bytes caused by one pixel, byte 0 goes out first.
    typedef struct packed {
        logic [QPE_MAX_BYTES-1:0][7:0] data;
        logic [2:0]                    count;
        logic                          eoi;
        logic                          saw;
    } qpe_rec_t;

    // Seen-pixel table index (3r + 5g + 7b + 11a) mod 64; only the low six
    // bits of each channel matter.
    function automatic logic [5:0] qpe_hash(input logic [31:0] pix);
        logic [5:0] h;
        h = pix[5:0] * 6'd3 + pix[13:8] * 6'd5 + pix[21:16] * 6'd7 + pix[29:24] * 6'd11;
        return h;
    endfunction

endpackage

`default_nettype wire

>>> design/qpe_front.sv
// Front end of the QOI pixel encoder: accepts pixels, looks up the seen-pixel
// table and turns each pixel into a byte record. Depends on qpe_pkg.
`default_nettype none

module qpe_front
    import qpe_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] in_pix,
    input  wire logic        in_eoi,
    output logic             push_valid,
    input  wire logic        push_ready,
    output qpe_rec_t         push_rec
);

    // Lookup stage registers.
    logic        s1_valid_reg, s1_valid_next;
    logic [31:0] s1_pix_reg;
    logic        s1_eoi_reg;
    logic [5:0]  s1_hash_reg;
    logic [31:0] rd_data_reg;
    logic        rd_vld_reg;
    logic        fwd_reg;

    // Encoder state.
    logic [31:0] prev_reg, prev_next;
    logic [5:0]  run_reg, run_next;
    logic        alpha_reg, alpha_next;
    logic [63:0] vld_reg, vld_next;
    logic [31:0] tbl_ram [64];

    logic        accept;
    logic        fire;
    logic [5:0]  in_hash;
    logic [31:0] entry;
    logic        same;
    logic        hit;
    logic [5:0]  run_inc;
    logic        flush;
    logic        tbl_we;
    logic [7:0]  dr, dg, db, sr, sg, sb, lg, lr, lb;
    logic [7:0]  enc [5];
    logic [2:0]  enc_cnt;
    qpe_rec_t    rec;

    assign in_hash  = qpe_hash(in_pix);
    assign fire     = s1_valid_reg && ((rec.count == 3'd0) || push_ready);
    assign in_ready = !s1_valid_reg || fire;
    assign accept   = in_valid && in_ready;

    // The entry written by the pixel just ahead is forwarded from prev_reg.
    assign entry   = fwd_reg ? prev_reg : (rd_vld_reg ? rd_data_reg : 32'd0);
    assign same    = (s1_pix_reg == prev_reg);
    assign hit     = (entry == s1_pix_reg);
    assign run_inc = run_reg + 6'd1;
    assign flush   = (run_inc == QPE_RUN_LIMIT) || s1_eoi_reg;
    assign tbl_we  = fire && !same;

    assign dr = s1_pix_reg[7:0]   - prev_reg[7:0];
    assign dg = s1_pix_reg[15:8]  - prev_reg[15:8];
    assign db = s1_pix_reg[23:16] - prev_reg[23:16];
    assign sr = dr + 8'd2;
    assign sg = dg + 8'd2;
    assign sb = db + 8'd2;
    assign lg = dg + 8'd32;
    assign lr = dr - dg + 8'd8;
    assign lb = db - dg + 8'd8;

    always_comb begin
        for (int i = 0; i < 5; i++) begin
            enc[i] = 8'd0;
        end
        if (hit) begin
            enc[0]  = QPE_TAG_INDEX | {2'b00, s1_hash_reg};
            enc_cnt = 3'd1;
        end else if (s1_pix_reg[31:24] != prev_reg[31:24]) begin
            enc[0]  = QPE_TAG_RGBA;
            enc[1]  = s1_pix_reg[7:0];
            enc[2]  = s1_pix_reg[15:8];
            enc[3]  = s1_pix_reg[23:16];
            enc[4]  = s1_pix_reg[31:24];
            enc_cnt = 3'd5;
        end else if (sr < 8'd4 && sg < 8'd4 && sb < 8'd4) begin
            enc[0]  = QPE_TAG_DIFF | {2'b00, sr[1:0], sg[1:0], sb[1:0]};
            enc_cnt = 3'd1;
        end else if (lg < 8'd64 && lr < 8'd16 && lb < 8'd16) begin
            enc[0]  = QPE_TAG_LUMA | {2'b00, lg[5:0]};
            enc[1]  = {lr[3:0], lb[3:0]};
            enc_cnt = 3'd2;
        end else begin
            enc[0]  = QPE_TAG_RGB;
            enc[1]  = s1_pix_reg[7:0];
            enc[2]  = s1_pix_reg[15:8];
            enc[3]  = s1_pix_reg[23:16];
            enc_cnt = 3'd4;
        end
    end

    always_comb begin
        rec.data  = '0;
        rec.count = 3'd0;
        rec.eoi   = s1_eoi_reg;
        rec.saw   = alpha_reg || (!same && s1_pix_reg[31:24] != 8'hff);
        if (same) begin
            rec.data[0] = QPE_TAG_RUN | {2'b00, run_reg};
            rec.count   = flush ? 3'd1 : 3'd0;
        end else if (run_reg != 6'd0) begin
            rec.data[0] = QPE_TAG_RUN | {2'b00, run_reg - 6'd1};
            for (int i = 0; i < 5; i++) begin
                rec.data[i+1] = enc[i];
            end
            rec.count = enc_cnt + 3'd1;
        end else begin
            for (int i = 0; i < 5; i++) begin
                rec.data[i] = enc[i];
            end
            rec.count = enc_cnt;
        end
    end

    assign push_valid = s1_valid_reg && (rec.count != 3'd0);
    assign push_rec   = rec;

    always_comb begin
        s1_valid_next = accept ? 1'b1 : (fire ? 1'b0 : s1_valid_reg);
        prev_next     = prev_reg;
        run_next      = run_reg;
        alpha_next    = alpha_reg;
        vld_next      = vld_reg;
        if (fire) begin
            if (s1_eoi_reg) begin
                prev_next  = QPE_PIX_RESET;
                run_next   = 6'd0;
                alpha_next = 1'b0;
                vld_next   = '0;
            end else if (same) begin
                run_next = flush ? 6'd0 : run_inc;
            end else begin
                prev_next             = s1_pix_reg;
                run_next              = 6'd0;
                alpha_next            = rec.saw;
                vld_next[s1_hash_reg] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            prev_reg     <= QPE_PIX_RESET;
            run_reg      <= 6'd0;
            alpha_reg    <= 1'b0;
            vld_reg      <= '0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            prev_reg     <= prev_next;
            run_reg      <= run_next;
            alpha_reg    <= alpha_next;
            vld_reg      <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg  <= in_pix;
            s1_eoi_reg  <= in_eoi;
            s1_hash_reg <= in_hash;
            rd_vld_reg  <= vld_next[in_hash];
            fwd_reg     <= tbl_we && !s1_eoi_reg && (s1_hash_reg == in_hash);
        end
    end

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_ram[s1_hash_reg] <= s1_pix_reg;
        end
        if (accept) begin
            rd_data_reg <= tbl_ram[in_hash];
        end
    end

endmodule

`default_nettype wire

>>> design/qpe_queue.sv
// Short record queue between the front and back ends of the encoder.
// Depends on qpe_pkg for the record type.
`default_nettype none

module qpe_queue
    import qpe_pkg::*;
#(
    parameter int DEPTH = QPE_QUEUE_DEPTH
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push_valid,
    output logic      push_ready,
    input  qpe_rec_t  push_rec,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output qpe_rec_t  pop_rec
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    qpe_rec_t      rec_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_rec    = rec_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            rec_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

`default_nettype wire

>>> design/qpe_back.sv
// Back end of the encoder: sends the bytes of each queued record one per
// cycle while out_ready is high, via a registered output stage; uses qpe_pkg.
`default_nettype none

module qpe_back
    import qpe_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic pop_valid,
    output logic      pop_ready,
    input  qpe_rec_t  pop_rec,
    output logic      out_valid,
    input  wire logic out_ready,
    output logic [7:0] out_byte,
    output logic      out_item_last,
    output logic      out_image_done,
    output logic      out_saw_alpha
);

    logic       valid_reg, valid_next;
    logic [2:0] idx_reg, idx_next;
    logic [7:0] byte_reg;
    logic       item_last_reg, done_reg, saw_reg;
    logic       load;
    logic       last;

    assign load      = pop_valid && (!valid_reg || out_ready);
    assign last      = (idx_reg == pop_rec.count - 3'd1);
    assign pop_ready = load && last;

    always_comb begin
        valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
        idx_next   = idx_reg;
        if (load) begin
            idx_next = last ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg      <= pop_rec.data[idx_reg];
            item_last_reg <= last;
            done_reg      <= last && pop_rec.eoi;
            saw_reg       <= last && pop_rec.eoi && pop_rec.saw;
        end
    end

    assign out_valid      = valid_reg;
    assign out_byte       = byte_reg;
    assign out_item_last  = item_last_reg;
    assign out_image_done = done_reg;
    assign out_saw_alpha  = saw_reg;

endmodule

`default_nettype wire

>>> design/qoi_pixel_encoder_core.sv
// QOI pixel encoder core, one pixel in and a stream of QOI chunk bytes out.
//
// The slave channel takes one RGBA pixel per transaction; tlast on it marks the
// final pixel of the image. The master channel gives one chunk byte per
// transaction: tuser[0] marks the last byte caused by a pixel, tlast the last
// byte of the image, and tuser[1], on that byte only, says that some pixel of
// the image had alpha below 255. A pixel that only extends a run gives no byte.
// Pixels are taken one per cycle as long as the record queue has room; the first
// byte of a pixel passes the lookup stage registers, the record queue and the
// output register in that order, and a pixel holds the output until all of its
// bytes have gone. Throughput is set by the byte serializer of the back end; a
// four-entry queue of per-pixel records lets the pixel side keep going while it
// drains. The seen-pixel table is a 64-entry memory read into a register when a
// pixel is accepted; its contents are qualified by valid flags that reset and the
// image-end pixel clear all together, so no clearing pass is needed.
// Reset (aresetn low, synchronous) empties the pipeline and queue and returns
// the encoder state to the start of an image. When the receiver stalls, the
// current byte holds on the master port, the queue fills, and then s_axis_tready
// drops until room frees up.
`default_nettype none
`include "qoi_pixel_encoder_core_defines.svh"

module qoi_pixel_encoder_core
    import qpe_pkg::*;
#(
    parameter int QUEUE_DEPTH = QPE_QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // pix_red [7:0], pix_green [15:8], pix_blue [23:16], pix_alpha [31:24]
    input  wire logic [31:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_byte [7:0]
    output logic [7:0]       m_axis_tdata,
    output logic             m_axis_tlast,
    // item_last [0], saw_alpha [1]
    output logic [1:0]       m_axis_tuser
);

    // Record handshake from the front end into the queue.
    logic     push_valid;
    logic     push_ready;
    qpe_rec_t push_rec;

    // Record handshake from the queue into the back end.
    logic     pop_valid;
    logic     pop_ready;
    qpe_rec_t pop_rec;

    // The front end classifies each pixel and updates the encoder state.
    qpe_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_pix     (s_axis_tdata),
        .in_eoi     (s_axis_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec)
    );

    qpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_rec    (pop_rec)
    );

    // The back end serializes each record onto the master port.
    qpe_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_rec        (pop_rec),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_byte       (m_axis_tdata),
        .out_item_last  (m_axis_tuser[0]),
        .out_image_done (m_axis_tlast),
        .out_saw_alpha  (m_axis_tuser[1])
    );

    // The image-end byte is always the last byte of its pixel.
    `QPE_ASSERT_IMP(a_done_is_item_last, m_axis_tvalid && m_axis_tlast, m_axis_tuser[0])
    // The alpha flag is only ever raised on the image-end byte.
    `QPE_ASSERT_IMP(a_saw_only_on_done, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast)
    // Every record entering the queue carries between one and six bytes.
    `QPE_ASSERT_IMP(a_push_count_range, push_valid && push_ready,
                    push_rec.count != 3'd0 && push_rec.count <= 3'(QPE_MAX_BYTES))
    // The front end keeps offering its record while the queue is full.
    `QPE_ASSERT_NXT(a_push_held, push_valid && !push_ready, push_valid)

endmodule

`default_nettype wire

>>> tb/tb_qoi_pixel_encoder_core.sv
// Self-checking testbench for qoi_pixel_encoder_core: random pixel streams in, QOI chunk bytes
// checked against an in-bench chunk predictor. Depends on qpe_pkg (tags, reset pixel, run
// limit) and on the core itself.
module tb_qoi_pixel_encoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    import qpe_pkg::*;

    localparam int RANDOM_PIXELS  = 64;
    localparam int IDLE_LIMIT     = 4000;
    localparam int TAIL_CYCLES    = 20;

    // One pixel waiting to be sent; hold asks the sender to wait for an empty byte store first.
    typedef struct packed {
        logic [31:0] px;
        logic        eoi;
        logic        hold;
    } pixel_item_t;

    // One predicted chunk byte with its side-band flags.
    typedef struct packed {
        logic [7:0] data;
        logic       item_last;
        logic       image_done;
        logic       saw_alpha;
    } chunk_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;

    qoi_pixel_encoder_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    pixel_item_t pixel_q[$];
    chunk_byte_t chunk_q[$];
    int          pixels_total = 0;
    int          pixels_sent = 0;
    int          mismatch_count = 0;

    // ------------------------------------------------------------------
    // Chunk predictor. It keeps its own copy of the encoder state: the
    // previous pixel, the 64-entry seen-pixel table (all zeros after reset,
    // so an all-zero pixel hits slot 0 at once), the run length and the
    // alpha flag. Pixel words use the package layout, red in the low byte.
    // ------------------------------------------------------------------
    logic [31:0] last_px;
    logic [31:0] seen_px [64];
    logic [5:0]  run_len;
    logic        alpha_flag;

    function automatic logic [31:0] rgba_word(input int r, input int g, input int b, input int a);
        return {8'(a), 8'(b), 8'(g), 8'(r)};
    endfunction

    function automatic logic [5:0] pixel_slot(input logic [31:0] px);
        int sum;
        sum = 3 * int'(px[7:0]) + 5 * int'(px[15:8]) + 7 * int'(px[23:16])
            + 11 * int'(px[31:24]);
        return sum[5:0];
    endfunction

    task automatic clear_predictor();
        last_px = QPE_PIX_RESET;
        foreach (seen_px[i]) seen_px[i] = '0;
        run_len = '0;
        alpha_flag = 1'b0;
    endtask

    // Works out every byte one accepted pixel causes and queues them in order.
    task automatic predict_chunks(input logic [31:0] px, input logic eoi);
        logic [7:0]  bytes_out [$];
        logic [5:0]  slot;
        logic [7:0]  dr, dg, db, sr, sg, sb, lg, lr, lb;
        chunk_byte_t cb;
        logic        tail;
        if (px == last_px) begin
            // A repeat only grows the run; it is flushed at the limit or at image end.
            run_len = run_len + 6'd1;
            if (run_len >= QPE_RUN_LIMIT || eoi) begin
                bytes_out.push_back(QPE_TAG_RUN | {2'b00, run_len - 6'd1});
                run_len = '0;
            end
        end else begin
            if (run_len != '0) begin
                bytes_out.push_back(QPE_TAG_RUN | {2'b00, run_len - 6'd1});
                run_len = '0;
            end
            slot = pixel_slot(px);
            if (seen_px[slot] == px) begin
                bytes_out.push_back(QPE_TAG_INDEX | {2'b00, slot});
            end else if (px[31:24] != last_px[31:24]) begin
                bytes_out.push_back(QPE_TAG_RGBA);
                bytes_out.push_back(px[7:0]);
                bytes_out.push_back(px[15:8]);
                bytes_out.push_back(px[23:16]);
                bytes_out.push_back(px[31:24]);
            end else begin
                // Channel differences wrap at 8 bits, as in the chunk format.
                dr = px[7:0] - last_px[7:0];
                dg = px[15:8] - last_px[15:8];
                db = px[23:16] - last_px[23:16];
                sr = dr + 8'd2;
                sg = dg + 8'd2;
                sb = db + 8'd2;
                lg = dg + 8'd32;
                lr = dr - dg + 8'd8;
                lb = db - dg + 8'd8;
                if (sr < 8'd4 && sg < 8'd4 && sb < 8'd4) begin
                    bytes_out.push_back(QPE_TAG_DIFF | {2'b00, sr[1:0], sg[1:0], sb[1:0]});
                end else if (lg < 8'd64 && lr < 8'd16 && lb < 8'd16) begin
                    bytes_out.push_back(QPE_TAG_LUMA | lg);
                    bytes_out.push_back({lr[3:0], lb[3:0]});
                end else begin
                    bytes_out.push_back(QPE_TAG_RGB);
                    bytes_out.push_back(px[7:0]);
                    bytes_out.push_back(px[15:8]);
                    bytes_out.push_back(px[23:16]);
                end
            end
            seen_px[slot] = px;
            last_px = px;
            if (px[31:24] != 8'hff) alpha_flag = 1'b1;
        end
        foreach (bytes_out[k]) begin
            tail = (k == bytes_out.size() - 1);
            cb.data       = bytes_out[k];
            cb.item_last  = tail;
            cb.image_done = tail && eoi;
            cb.saw_alpha  = tail && eoi && alpha_flag;
            chunk_q.push_back(cb);
        end
        // The image-end pixel returns everything to the start of a new image.
        if (eoi) clear_predictor();
    endtask

    // ------------------------------------------------------------------
    // Stimulus generation. The generator tracks the previous pixel and the
    // recent pixels of the current image so it can aim at runs, table hits
    // and small differences instead of only random colors.
    // ------------------------------------------------------------------
    logic [31:0] gen_prev = QPE_PIX_RESET;
    logic [31:0] gen_recent [$];

    task automatic add_pixel(input logic [31:0] px, input logic eoi, input logic hold);
        pixel_item_t it;
        it.px = px;
        it.eoi = eoi;
        it.hold = hold;
        pixel_q.push_back(it);
        pixels_total++;
        if (eoi) begin
            gen_prev = QPE_PIX_RESET;
            gen_recent.delete();
        end else begin
            gen_prev = px;
            gen_recent.push_back(px);
            if (gen_recent.size() > 16) void'(gen_recent.pop_front());
        end
    endtask

    function automatic logic pick_eoi();
        return ($urandom_range(0, 24) == 0);
    endfunction

    function automatic int pick_delay();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic build_stimulus();
        int          made;
        int          mode;
        int          len;
        int          dgv;
        int          drv;
        int          dbv;
        logic [31:0] px;
        // Directed part. A repeat of the reset pixel starts a run at once,
        // and an image-end mark on a repeat flushes it with the done flags.
        add_pixel(rgba_word(0, 0, 0, 255), 1'b0, 1'b0);
        add_pixel(rgba_word(0, 0, 0, 255), 1'b1, 1'b0);
        // All-zero pixel matches the cleared table entry of slot 0.
        add_pixel(rgba_word(0, 0, 0, 0), 1'b0, 1'b0);
        // Alpha change goes to an rgba chunk; then the diff wraps around 255.
        add_pixel(rgba_word(255, 255, 255, 255), 1'b0, 1'b0);
        add_pixel(rgba_word(0, 0, 0, 255), 1'b0, 1'b0);
        add_pixel(rgba_word(1, 255, 0, 255), 1'b0, 1'b0);
        // Luma chunks, mid-range and at the range ends (green and red top, blue bottom), an rgb chunk between.
        add_pixel(rgba_word(10, 8, 12, 255), 1'b0, 1'b0);
        add_pixel(rgba_word(214, 232, 243, 255), 1'b0, 1'b0);
        add_pixel(rgba_word(252, 7, 10, 255), 1'b0, 1'b0);
        // Too far for luma: plain rgb chunk.
        add_pixel(rgba_word(100, 200, 50, 255), 1'b0, 1'b0);
        // Earlier white pixel again, likely still in the table.
        add_pixel(rgba_word(255, 255, 255, 255), 1'b0, 1'b0);
        add_pixel(rgba_word(255, 255, 255, 255), 1'b0, 1'b0);
        add_pixel(rgba_word(255, 255, 255, 255), 1'b0, 1'b0);
        add_pixel(rgba_word(255, 255, 255, 255), 1'b0, 1'b0);
        // A different pixel flushes the pending run before its own chunk.
        add_pixel(rgba_word(0, 0, 0, 128), 1'b0, 1'b0);
        add_pixel(rgba_word(0, 0, 0, 128), 1'b1, 1'b0);
        // Single-pixel image with transparent alpha.
        add_pixel(rgba_word(255, 255, 255, 0), 1'b1, 1'b0);
        // The sender holds this one back until every byte so far has come out.
        add_pixel(rgba_word(17, 34, 51, 255), 1'b0, 1'b1);
        add_pixel(rgba_word(17, 34, 51, 255), 1'b1, 1'b0);

        // A long run that hits the run limit once and is flushed by the image end.
        add_pixel(rgba_word($urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255), 255), 1'b0, 1'b0);
        for (int i = 0; i < 64; i++) add_pixel(gen_prev, (i == 63), 1'b0);

        // Random part, weighted toward chunks other than rgb.
        made = 0;
        while (made < RANDOM_PIXELS) begin
            mode = $urandom_range(0, 99);
            if (mode < 15) begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++) add_pixel(gen_prev, pick_eoi(), 1'b0);
                made += len;
            end else begin
                if (mode < 35) begin
                    if (gen_recent.size() > 0)
                        px = gen_recent[$urandom_range(0, gen_recent.size() - 1)];
                    else
                        px = $urandom();
                end else if (mode < 55) begin
                    px = gen_prev;
                    px[7:0]   = gen_prev[7:0] + 8'(int'($urandom_range(0, 3)) - 2);
                    px[15:8]  = gen_prev[15:8] + 8'(int'($urandom_range(0, 3)) - 2);
                    px[23:16] = gen_prev[23:16] + 8'(int'($urandom_range(0, 3)) - 2);
                end else if (mode < 75) begin
                    dgv = int'($urandom_range(0, 63)) - 32;
                    drv = dgv + int'($urandom_range(0, 15)) - 8;
                    dbv = dgv + int'($urandom_range(0, 15)) - 8;
                    px = gen_prev;
                    px[7:0]   = gen_prev[7:0] + 8'(drv);
                    px[15:8]  = gen_prev[15:8] + 8'(dgv);
                    px[23:16] = gen_prev[23:16] + 8'(dbv);
                end else if (mode < 90) begin
                    px = {gen_prev[31:24], 24'($urandom())};
                end else begin
                    px = $urandom();
                    if ($urandom_range(0, 2) == 0) px[31:24] = 8'hff;
                end
                add_pixel(px, pick_eoi(), ($urandom_range(0, 29) == 0));
                made++;
            end
        end
        // Close the stream with an image end so any run is flushed.
        add_pixel($urandom(), 1'b1, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Driver. Each accepted slave transaction is handed to the predictor on
    // the edge that accepts it. A new pixel is presented only when the slot
    // is free; random gaps lower tvalid between pixels, and a burst mode
    // that toggles now and then gives stretches without gaps.
    // ------------------------------------------------------------------
    int drv_gap = 0;
    bit drv_burst = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_chunks(s_axis_tdata, s_axis_tlast);
                pixels_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pixel_q.size() > 0 && !(pixel_q[0].hold && chunk_q.size() > 0)) begin
                    s_axis_tdata  <= pixel_q[0].px;
                    s_axis_tlast  <= pixel_q[0].eoi;
                    s_axis_tvalid <= 1'b1;
                    void'(pixel_q.pop_front());
                    if ($urandom_range(0, 39) == 0) drv_burst = !drv_burst;
                    drv_gap = drv_burst ? 0 : pick_delay();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor. Every accepted master transaction is matched against the
    // oldest predicted byte. tready stalls at random, short mostly, with
    // occasional long stalls and stall-free stretches.
    // ------------------------------------------------------------------
    int          mon_stall = 0;
    bit          mon_burst = 1'b0;
    chunk_byte_t mon_exp;
    chunk_byte_t mon_got;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                mon_got.data       = m_axis_tdata;
                mon_got.item_last  = m_axis_tuser[0];
                mon_got.image_done = m_axis_tlast;
                mon_got.saw_alpha  = m_axis_tuser[1];
                if (chunk_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected byte: expected none, actual %h/%b/%b/%b",
                             $time, mon_got.data, mon_got.item_last, mon_got.image_done,
                             mon_got.saw_alpha);
                end else begin
                    mon_exp = chunk_q.pop_front();
                    if (mon_got !== mon_exp) begin
                        mismatch_count++;
                        $display("%0t: byte mismatch: expected %h/%b/%b/%b, actual %h/%b/%b/%b",
                                 $time, mon_exp.data, mon_exp.item_last, mon_exp.image_done,
                                 mon_exp.saw_alpha, mon_got.data, mon_got.item_last,
                                 mon_got.image_done, mon_got.saw_alpha);
                    end
                end
            end
            if ($urandom_range(0, 49) == 0) mon_burst = !mon_burst;
            if (mon_stall > 0) begin
                mon_stall--;
                m_axis_tready <= 1'b0;
            end else if (!mon_burst && $urandom_range(0, 4) == 0) begin
                mon_stall = pick_delay();
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: a run of cycles without any transaction on either side means a hang.
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Sequence: build the stimulus, release reset, then wait for every pixel to be
    // taken and every predicted byte to arrive. The tail lets any stray byte show
    // up before the verdict.
    initial begin
        clear_predictor();
        build_stimulus();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pixels_sent == pixels_total);
        wait (chunk_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && chunk_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
